// File: design/multi_task_watchdog_top_macros.svh
// assertion macros for the multi-task watchdog top level
`ifndef MULTI_TASK_WATCHDOG_TOP_MACROS_SVH
`define MULTI_TASK_WATCHDOG_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mtw_pkg.sv
// shared types and constants of the multi-task watchdog
package mtw_pkg;

	// default number of supervised slots
	localparam int unsigned MAX_SLOTS_DEF = 16;

	// entries of the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_REGISTER = 2'd1,
		OP_KICK     = 2'd2,
		OP_CHECK    = 2'd3
	} mtw_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ERR  = 2'd1,
		ST_HANG = 2'd2
	} mtw_status_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_SCAN = 1'b1
	} mtw_back_state_t;

	// one classified command as it travels through the queue
	typedef struct packed {
		mtw_op_t     op;
		logic [3:0]  idx;
		logic [31:0] timeout;
	} mtw_cmd_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic valid;
	} mtw_qstat_t;

endpackage

// File: design/multi_task_watchdog_top.sv
// Multi-task watchdog: a command is accepted at a clock edge with start high and busy
// low; its single result shows on the result ports for one cycle with done high and
// cannot be held off. Tick, register and kick complete as they are popped; a check reads
// the slot tables one entry per cycle and ends at the first slot found hung or after
// the last registered slot, and gives its result at once when no slot is registered.
// A two-entry command queue and an input stage let up to three commands be taken ahead
// of execution, after which busy stays high until the execution unit pops a command
// from the queue. Results follow the accepted commands in order.
`include "multi_task_watchdog_top_macros.svh"

module multi_task_watchdog_top #(
	parameter int unsigned MAX_SLOTS = mtw_pkg::MAX_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  mode,
	input  logic [3:0]  task_index,
	input  logic [31:0] timeout,
	output logic        busy,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  hung_task,
	output logic [3:0]  new_slot,
	output logic [31:0] checks_done
);

	mtw_pkg::mtw_qstat_t qstat;
	mtw_pkg::mtw_cmd_t   push_cmd;
	mtw_pkg::mtw_cmd_t   head_cmd;
	logic                push;
	logic                pop;

	// accept and decode
	mtw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.task_index (task_index),
		.timeout    (timeout),
		.qstat      (qstat),
		.busy       (busy),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// decoupling queue
	mtw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.qstat    (qstat),
		.head_cmd (head_cmd)
	);

	// execution
	mtw_back #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.done        (done),
		.status      (status),
		.hung_task   (hung_task),
		.new_slot    (new_slot),
		.checks_done (checks_done)
	);

	// checks on queue use and result consistency
	`MTW_ASSERT_NOW(a_pop_nonempty, pop, qstat.valid, "pop from empty command queue")
	`MTW_ASSERT_NOW(a_push_notfull, push, !qstat.full, "push into full command queue")
	`MTW_ASSERT_NEXT(a_busy_holds, busy && !pop, busy, "busy dropped without a queue pop")
	`MTW_ASSERT_NOW(a_hung_only_hang, done && hung_task != 4'd0,
		status == mtw_pkg::ST_HANG, "hung slot reported without hang status")

endmodule

// File: design/mtw_front.sv
// front end: takes input transactions, decodes the mode and feeds the queue
module mtw_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        mode,
	input  logic [3:0]        task_index,
	input  logic [31:0]       timeout,
	input  mtw_pkg::mtw_qstat_t qstat,
	output logic              busy,
	output logic              push,
	output mtw_pkg::mtw_cmd_t push_cmd
);

	logic              valid_s1;
	mtw_pkg::mtw_cmd_t cmd_s1;
	mtw_pkg::mtw_cmd_t cmd_dec;
	logic              accept;

	// decode the mode into an operation
	always_comb begin
		cmd_dec.idx     = task_index;
		cmd_dec.timeout = timeout;
		case (mode)
			mtw_pkg::OP_TICK:     cmd_dec.op = mtw_pkg::OP_TICK;
			mtw_pkg::OP_REGISTER: cmd_dec.op = mtw_pkg::OP_REGISTER;
			mtw_pkg::OP_KICK:     cmd_dec.op = mtw_pkg::OP_KICK;
			default: cmd_dec.op = mtw_pkg::OP_CHECK;
		endcase
	end

	// hold off new transactions while the stage waits on a full queue
	assign busy   = valid_s1 & qstat.full;
	assign accept = start & ~busy;
	assign push   = valid_s1 & ~qstat.full;
	assign push_cmd = cmd_s1;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | busy;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

// File: design/mtw_queue.sv
// small command queue between front and back
module mtw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mtw_pkg::mtw_cmd_t push_cmd,
	input  logic              pop,
	output mtw_pkg::mtw_qstat_t qstat,
	output mtw_pkg::mtw_cmd_t head_cmd
);

	localparam int unsigned DEPTH = mtw_pkg::QUEUE_DEPTH;
	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW    = $clog2(DEPTH + 1);

	mtw_pkg::mtw_cmd_t entry_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;

	assign qstat.full  = (count_q == NW'(DEPTH));
	assign qstat.valid = (count_q != '0);
	assign head_cmd    = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= NW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= NW'(count_q - 1'b1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: design/mtw_back.sv
// back end: slot tables, millisecond clock, check scan and result registers
module mtw_back #(
	parameter int unsigned MAX_SLOTS = mtw_pkg::MAX_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mtw_pkg::mtw_qstat_t qstat,
	input  mtw_pkg::mtw_cmd_t head_cmd,
	output logic              pop,
	output logic              done,
	output logic [1:0]        status,
	output logic [3:0]        hung_task,
	output logic [3:0]        new_slot,
	output logic [31:0]       checks_done
);

	localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
	localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	mtw_pkg::mtw_back_state_t state_q, state_d;

	logic [31:0]   now_q;
	logic [CW-1:0] count_q;
	logic [31:0]   total_q;
	logic [CW-1:0] scan_q;

	// slot tables
	logic [31:0] tmo_mem [MAX_SLOTS];
	logic [31:0] kick_mem [MAX_SLOTS];

	// scan read pipeline
	logic          rd_vld_s1;
	logic [CW-1:0] rd_idx_s1;
	logic [31:0]   rd_tmo_s1;
	logic [31:0]   rd_kick_s1;

	// result registers
	logic                 done_q;
	mtw_pkg::mtw_status_t status_q;
	logic [3:0]           hung_q;
	logic [3:0]           new_q;

	// control from the output decode
	logic                 now_inc, count_inc, total_inc, scan_clr;
	logic                 wr_tmo, wr_kick, rd_en;
	logic [AW-1:0]        wr_addr;
	logic                 res_vld;
	mtw_pkg::mtw_status_t res_status;
	logic [3:0]           res_hung, res_new;

	// derived compares
	logic [CW+3:0] idx_wide;
	logic [CW+3:0] count_wide;
	logic [CW+3:0] rd_idx_wide;
	logic [CW+3:0] new_wide;
	logic          idx_ok;
	logic          table_full;
	logic [31:0]   age;
	logic          hit;
	logic          last;

	assign idx_wide    = {{CW{1'b0}}, head_cmd.idx};
	assign count_wide  = {4'b0, count_q};
	assign rd_idx_wide = {4'b0, rd_idx_s1};
	assign new_wide    = {4'b0, count_q};
	assign idx_ok      = (idx_wide < count_wide);
	assign table_full  = (count_q == CW'(MAX_SLOTS));
	assign age         = now_q - rd_kick_s1;
	assign hit         = rd_vld_s1 & (age > rd_tmo_s1);
	assign last        = rd_vld_s1 & (CW'(rd_idx_s1 + 1'b1) == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtw_pkg::BK_IDLE: begin
				if (qstat.valid && head_cmd.op == mtw_pkg::OP_CHECK && count_q != '0) begin
					state_d = mtw_pkg::BK_SCAN;
				end
			end
			mtw_pkg::BK_SCAN: begin
				if (hit || last) begin
					state_d = mtw_pkg::BK_IDLE;
				end
			end
			default: state_d = mtw_pkg::BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop        = 1'b0;
		now_inc    = 1'b0;
		count_inc  = 1'b0;
		total_inc  = 1'b0;
		scan_clr   = 1'b0;
		wr_tmo     = 1'b0;
		wr_kick    = 1'b0;
		wr_addr    = count_q[AW-1:0];
		rd_en      = 1'b0;
		res_vld    = 1'b0;
		res_status = mtw_pkg::ST_OK;
		res_hung   = 4'd0;
		res_new    = 4'd0;
		case (state_q)
			mtw_pkg::BK_IDLE: begin
				if (qstat.valid) begin
					pop = 1'b1;
					case (head_cmd.op)
						mtw_pkg::OP_TICK: begin
							now_inc = 1'b1;
							res_vld = 1'b1;
						end
						mtw_pkg::OP_REGISTER: begin
							res_vld = 1'b1;
							if (table_full) begin
								res_status = mtw_pkg::ST_ERR;
							end else begin
								wr_tmo    = 1'b1;
								wr_kick   = 1'b1;
								count_inc = 1'b1;
								res_new   = new_wide[3:0];
							end
						end
						mtw_pkg::OP_KICK: begin
							res_vld = 1'b1;
							wr_addr = idx_wide[AW-1:0];
							if (idx_ok) begin
								wr_kick = 1'b1;
							end else begin
								res_status = mtw_pkg::ST_ERR;
							end
						end
						default: begin
							total_inc = 1'b1;
							scan_clr  = 1'b1;
							if (count_q == '0) begin
								res_vld = 1'b1;
							end
						end
					endcase
				end
			end
			mtw_pkg::BK_SCAN: begin
				if (hit) begin
					res_vld    = 1'b1;
					res_status = mtw_pkg::ST_HANG;
					res_hung   = rd_idx_wide[3:0];
				end else if (last) begin
					res_vld = 1'b1;
				end else if (scan_q < count_q) begin
					rd_en = 1'b1;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// control and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mtw_pkg::BK_IDLE;
			now_q     <= '0;
			count_q   <= '0;
			total_q   <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			done_q    <= res_vld;
			if (now_inc) begin
				now_q <= now_q + 32'd1;
			end
			if (count_inc) begin
				count_q <= CW'(count_q + 1'b1);
			end
			if (total_inc) begin
				total_q <= total_q + 32'd1;
			end
			if (scan_clr) begin
				scan_q <= '0;
			end else if (rd_en) begin
				scan_q <= CW'(scan_q + 1'b1);
			end
		end
	end

	// timeout table
	always_ff @(posedge clk) begin
		if (wr_tmo) begin
			tmo_mem[wr_addr] <= head_cmd.timeout;
		end
		if (rd_en) begin
			rd_tmo_s1 <= tmo_mem[scan_q[AW-1:0]];
		end
	end

	// last kick table
	always_ff @(posedge clk) begin
		if (wr_kick) begin
			kick_mem[wr_addr] <= now_q;
		end
		if (rd_en) begin
			rd_kick_s1 <= kick_mem[scan_q[AW-1:0]];
		end
	end

	// scan index follows the read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= scan_q;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_vld) begin
			status_q <= res_status;
			hung_q   <= res_hung;
			new_q    <= res_new;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign hung_task   = hung_q;
	assign new_slot    = new_q;
	assign checks_done = total_q;

endmodule

// File: test/multi_task_watchdog_top_test.sv
// self-checking testbench for the multi-task watchdog: directed and random command streams
module multi_task_watchdog_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = mtw_pkg::MAX_SLOTS_DEF;
	localparam int unsigned TARGET_ITEMS = 1900;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = '0;
	logic [3:0]  task_index = '0;
	logic [31:0] timeout = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [3:0]  hung_task;
	logic [3:0]  new_slot;
	logic [31:0] checks_done;

	bit          no_idle = 1'b0;
	int unsigned items_sent = 0;

	// shadow of the slot table and queue of awaited reports
	class watchdog_scoreboard;
		typedef struct {
			mtw_pkg::mtw_status_t status;
			logic [3:0]  hung_task;
			logic [3:0]  new_slot;
			logic [31:0] checks_done;
		} report_t;

		logic [31:0] now_ms;
		int unsigned slot_count;
		logic [31:0] slot_timeout [SLOTS];
		logic [31:0] slot_last_kick [SLOTS];
		logic [31:0] check_total;
		report_t     awaited_reports [$];
		int unsigned mismatches;

		function new();
			now_ms = '0;
			slot_count = 0;
			check_total = '0;
			mismatches = 0;
		endfunction

		// apply one accepted transaction and queue the report it should give
		function void note_command(mtw_pkg::mtw_op_t op, logic [3:0] idx, logic [31:0] tmo);
			report_t     rep;
			logic [31:0] age;
			bit          hung;
			int          i;
			rep.status = mtw_pkg::ST_OK;
			rep.hung_task = '0;
			rep.new_slot = '0;
			hung = 1'b0;
			case (op)
				mtw_pkg::OP_TICK: begin
					now_ms = now_ms + 32'd1;
				end
				mtw_pkg::OP_REGISTER: begin
					if (slot_count >= SLOTS) begin
						rep.status = mtw_pkg::ST_ERR;
					end else begin
						slot_timeout[slot_count] = tmo;
						slot_last_kick[slot_count] = now_ms;
						rep.new_slot = slot_count[3:0];
						slot_count = slot_count + 1;
					end
				end
				mtw_pkg::OP_KICK: begin
					if (idx >= slot_count) begin
						rep.status = mtw_pkg::ST_ERR;
					end else begin
						slot_last_kick[idx] = now_ms;
					end
				end
				default: begin
					// first registered slot whose wrapping age exceeds its timeout
					check_total = check_total + 32'd1;
					for (i = 0; i < slot_count && !hung; i++) begin
						age = now_ms - slot_last_kick[i];
						if (age > slot_timeout[i]) begin
							hung = 1'b1;
							rep.status = mtw_pkg::ST_HANG;
							rep.hung_task = i[3:0];
						end
					end
				end
			endcase
			rep.checks_done = check_total;
			awaited_reports.push_back(rep);
		endfunction

		// compare one result transaction with the oldest awaited report
		function void check_result(logic [1:0] got_status, logic [3:0] got_hung,
				logic [3:0] got_slot, logic [31:0] got_checks);
			report_t want;
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result: status %0d hung %0d slot %0d checks %0d",
						$realtime, got_status, got_hung, got_slot, got_checks);
			end else begin
				want = awaited_reports.pop_front();
				if (got_status !== want.status || got_hung !== want.hung_task ||
						got_slot !== want.new_slot || got_checks !== want.checks_done) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch: expected status %0d hung %0d slot %0d checks %0d",
							$realtime, want.status, want.hung_task, want.new_slot,
							want.checks_done);
						$display("%0t:           actual status %0d hung %0d slot %0d checks %0d",
							$realtime, got_status, got_hung, got_slot, got_checks);
					end
				end
			end
		endfunction
	endclass

	watchdog_scoreboard sb;

	multi_task_watchdog_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.task_index  (task_index),
		.timeout     (timeout),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.hung_task   (hung_task),
		.new_slot    (new_slot),
		.checks_done (checks_done)
	);

	// clock
	always #5 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, hung_task, new_slot, checks_done);
	end

	// present one command after a random gap, none while no_idle is set, and wait until it is taken
	task automatic send_cmd(input mtw_pkg::mtw_op_t op, input logic [3:0] idx,
			input logic [31:0] tmo);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		mode <= op;
		task_index <= idx;
		timeout <= tmo;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(op, idx, tmo);
		items_sent++;
		@(negedge clk);
	endtask

	// stop sending until every awaited report has come
	task automatic hold_until_drained();
		start <= 1'b0;
		@(negedge clk);
		while (sb.awaited_reports.size() != 0) @(negedge clk);
	endtask

	// stimulus
	initial begin
		int unsigned pick;
		int unsigned roll;
		int          s;
		bit          kick_all;
		mtw_pkg::mtw_op_t op;
		logic [3:0]  idx;
		logic [31:0] tmo;

		sb = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty table, unknown slots, zero and maximum timeouts, hangs
		send_cmd(mtw_pkg::OP_CHECK, 4'hf, 32'hffff_ffff);
		send_cmd(mtw_pkg::OP_KICK, 4'h0, 32'h0);
		send_cmd(mtw_pkg::OP_REGISTER, 4'hf, 32'h0);
		send_cmd(mtw_pkg::OP_CHECK, 4'h0, 32'h0);
		send_cmd(mtw_pkg::OP_TICK, 4'h0, 32'h0);
		send_cmd(mtw_pkg::OP_CHECK, 4'h0, 32'h0);
		send_cmd(mtw_pkg::OP_KICK, 4'h0, 32'hffff_ffff);
		send_cmd(mtw_pkg::OP_CHECK, 4'h0, 32'h0);
		send_cmd(mtw_pkg::OP_REGISTER, 4'h0, 32'hffff_ffff);
		send_cmd(mtw_pkg::OP_REGISTER, 4'ha, 32'd3);
		send_cmd(mtw_pkg::OP_KICK, 4'hf, 32'hffff_ffff);
		send_cmd(mtw_pkg::OP_KICK, 4'h3, 32'h0);
		repeat (4) send_cmd(mtw_pkg::OP_TICK, 4'h5, 32'h5555_aaaa);
		send_cmd(mtw_pkg::OP_KICK, 4'h0, 32'h0);
		send_cmd(mtw_pkg::OP_CHECK, 4'h0, 32'h0);
		send_cmd(mtw_pkg::OP_KICK, 4'h2, 32'h0);
		send_cmd(mtw_pkg::OP_KICK, 4'h1, 32'h0);
		send_cmd(mtw_pkg::OP_CHECK, 4'h0, 32'h0);
		send_cmd(mtw_pkg::OP_TICK, 4'hf, 32'hffff_ffff);
		send_cmd(mtw_pkg::OP_CHECK, 4'hf, 32'hffff_ffff);
		hold_until_drained();

		// random: free commands, service rounds and runs of ticks
		while (items_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
			if ($urandom_range(0, 39) == 0) hold_until_drained();
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// one free-form command
				roll = $urandom_range(0, 99);
				idx = 4'($urandom_range(0, 15));
				tmo = $urandom;
				if (roll < 8) begin
					op = mtw_pkg::OP_REGISTER;
					roll = $urandom_range(0, 99);
					if (roll < 15) tmo = '0;
					else if (roll < 25) tmo = '1;
					else if (roll < 70) tmo = $urandom_range(1, 30);
				end else if (roll < 48) begin
					op = mtw_pkg::OP_TICK;
				end else if (roll < 75) begin
					op = mtw_pkg::OP_KICK;
				end else begin
					op = mtw_pkg::OP_CHECK;
				end
				send_cmd(op, idx, tmo);
			end else if (pick < 80) begin
				// service round: kick registered slots, then check
				kick_all = 1'($urandom_range(0, 1));
				for (s = 0; s < sb.slot_count; s++) begin
					if (kick_all || $urandom_range(0, 9) < 7)
						send_cmd(mtw_pkg::OP_KICK, s[3:0], $urandom);
				end
				if ($urandom_range(0, 3) == 0)
					send_cmd(mtw_pkg::OP_TICK, 4'($urandom), $urandom);
				send_cmd(mtw_pkg::OP_CHECK, 4'($urandom), $urandom);
			end else begin
				// let time run, then check
				repeat ($urandom_range(1, 8))
					send_cmd(mtw_pkg::OP_TICK, 4'($urandom), $urandom);
				send_cmd(mtw_pkg::OP_CHECK, 4'($urandom), $urandom);
			end
		end

		// drain and settle
		hold_until_drained();
		repeat (64) @(negedge clk);
		if (sb.mismatches == 0 && sb.awaited_reports.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
